### rtl/core/sdff_pkg.sv
`timescale 1ns / 1ps

package sdff_pkg;

   // Field limits.
   localparam logic [5:0] MAX_WIDTH  = 6'd63;
   localparam int         MAX_DIGITS = 10;
   localparam logic [5:0] PREC_CAP   = 6'd61;

   // Binary to BCD conversion takes one shift per magnitude bit.
   localparam int         MAG_BITS   = 32;

   // Characters.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   typedef struct packed {
      logic signed [31:0] value;
      logic               left_justify;
      logic               zero_pad;
      logic               has_precision;
      logic               space_sign;
      logic               plus_sign;
      logic [5:0]         field_width;
      logic [5:0]         min_digits;
   } req_type;

   typedef struct packed {
      logic [7:0] ascii_char;
      logic       last_char;
   } rsp_type;

endpackage

### rtl/core/signed_decimal_field_formatter_core.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  req_data  (sdff_pkg::req_type)
// rsp_      out        rsp_valid / rsp_ready  rsp_data  (sdff_pkg::rsp_type)
//
// An item yields N characters, N being 0 to 63: binary to BCD shifting through the digit
// registers, then the ST_COUNT, ST_ZERO and ST_LAYOUT states for digit count, zero-fill count
// and field layout, then one character per cycle from the output register while not stalled.
// req_ready is high only while the sequencer is idle; a last character may still wait in
// the output register then. A stalled rsp_ready holds the character sequencer.
// Synchronous reset clears the sequencer and the output valid; digit registers are not reset.
`timescale 1ns / 1ps

module signed_decimal_field_formatter_core
   import sdff_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CONV   = 3'd1;
   localparam logic [2:0] ST_COUNT  = 3'd2;
   localparam logic [2:0] ST_ZERO   = 3'd3;
   localparam logic [2:0] ST_LAYOUT = 3'd4;
   localparam logic [2:0] ST_EMIT   = 3'd5;

   logic [2:0]        state_ff, state_in;
   req_type           req_ff, req_in;
   logic [31:0]       mag_ff, mag_in;
   logic [3:0]        digit_store_ff [MAX_DIGITS];
   logic [3:0]        digit_store_in [MAX_DIGITS];
   logic [3:0]        digit_count_ff, digit_count_in;
   logic [6:0]        emit_counter_ff, emit_counter_in;
   logic signed [7:0] zero_ff, zero_in;
   logic [3:0]        used_ff, used_in;
   logic [6:0]        b_sp_ff, b_lpad_ff, b_sign_ff, b_zero_ff, b_dig_ff, total_ff;
   logic [6:0]        b_sp_in, b_lpad_in, b_sign_in, b_zero_in, b_dig_in, total_in;
   logic [3:0]        dptr_ff, dptr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // Decoded spec, taken from the stored request.
   logic              neg, pos, is_zero, print_digits;
   logic [5:0]        w_sat, p_sat;
   logic [3:0]        len;
   logic signed [7:0] sl, sp8, sw8, zero_v, pad_v;
   logic [6:0]        pad_pos, zeros, n_lpad, n_rpad, n_dig;
   logic              n_sp, n_sign;
   logic [3:0]        adj [MAX_DIGITS];
   logic [3:0]        count_v;
   logic              load;
   logic [7:0]        char_v;
   logic              is_digit;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign neg          = req_ff.value[31];
   assign pos          = !neg;
   assign is_zero      = (req_ff.value == 32'sd0);
   assign w_sat        = (req_ff.field_width > MAX_WIDTH) ? MAX_WIDTH : req_ff.field_width;
   assign p_sat        = (req_ff.min_digits > PREC_CAP) ? PREC_CAP : req_ff.min_digits;
   assign print_digits = !(req_ff.has_precision && (p_sat == 6'd0) && is_zero);
   assign len          = print_digits ? (digit_count_ff + {3'd0, neg}) : 4'd0;
   assign sl           = $signed({4'd0, len});
   assign sp8          = $signed({2'd0, p_sat});
   assign sw8          = $signed({2'd0, w_sat});

   // Add-3 correction of every BCD digit before each shift.
   always_comb begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
         adj[i] = (digit_store_ff[i] >= 4'd5) ? (digit_store_ff[i] + 4'd3) : digit_store_ff[i];
      end
   end

   // Position of the most significant nonzero digit; zero still shows one digit.
   always_comb begin
      count_v = 4'd1;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (digit_store_ff[i] != 4'd0) begin
            count_v = 4'(i + 1);
         end
      end
   end

   // Zero-fill count. Sign flags under zero pad may drive it below zero.
   always_comb begin
      zero_v = 8'sd0;
      if (req_ff.zero_pad || req_ff.has_precision) begin
         if (req_ff.has_precision && pos && (sp8 > sl)) begin
            zero_v = sp8 - sl;
         end else if (req_ff.has_precision && neg && (sp8 > (sl - 8'sd1))) begin
            zero_v = sp8 - sl + 8'sd1;
         end else if (req_ff.zero_pad && !req_ff.has_precision && (sw8 > sl)) begin
            zero_v = sw8 - sl;
         end
         if (req_ff.space_sign && !req_ff.has_precision && pos) begin
            zero_v = zero_v - 8'sd1;
         end
         if (req_ff.plus_sign && !req_ff.has_precision && pos) begin
            zero_v = zero_v - 8'sd1;
         end
      end
   end

   // Layout of the field as cumulative segment ends.
   always_comb begin
      pad_v   = sw8 - zero_ff - $signed({4'd0, used_ff});
      pad_pos = (pad_v > 8'sd0) ? pad_v[6:0] : 7'd0;
      zeros   = (zero_ff > 8'sd0) ? zero_ff[6:0] : 7'd0;
      n_sp    = req_ff.space_sign && pos;
      n_sign  = (req_ff.plus_sign && pos) || (neg && print_digits);
      n_lpad  = req_ff.left_justify ? 7'd0 : pad_pos;
      n_rpad  = req_ff.left_justify ? pad_pos : 7'd0;
      n_dig   = print_digits ? {3'd0, digit_count_ff} : 7'd0;
      b_sp_in   = {6'd0, n_sp};
      b_lpad_in = b_sp_in + n_lpad;
      b_sign_in = b_lpad_in + {6'd0, n_sign};
      b_zero_in = b_sign_in + zeros;
      b_dig_in  = b_zero_in + n_dig;
      total_in  = b_dig_in + n_rpad;
   end

   // Character at the current position.
   always_comb begin
      is_digit = 1'b0;
      priority if (emit_counter_ff < b_sp_ff) begin
         char_v = CHAR_SPACE;
      end else if (emit_counter_ff < b_lpad_ff) begin
         char_v = (req_ff.zero_pad && !req_ff.has_precision) ? CHAR_ZERO : CHAR_SPACE;
      end else if (emit_counter_ff < b_sign_ff) begin
         char_v = neg ? CHAR_MINUS : CHAR_PLUS;
      end else if (emit_counter_ff < b_zero_ff) begin
         char_v = CHAR_ZERO;
      end else if (emit_counter_ff < b_dig_ff) begin
         char_v   = CHAR_ZERO + {4'd0, digit_store_ff[dptr_ff]};
         is_digit = 1'b1;
      end else begin
         char_v = CHAR_SPACE;
      end
   end

   assign load = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in        = state_ff;
      req_in          = req_ff;
      mag_in          = mag_ff;
      digit_store_in  = digit_store_ff;
      digit_count_in  = digit_count_ff;
      emit_counter_in = emit_counter_ff;
      zero_in         = zero_ff;
      used_in         = used_ff;
      dptr_in         = dptr_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in          = req_data;
               mag_in          = req_data.value[31] ? (32'd0 - req_data.value) : req_data.value;
               emit_counter_in = 7'd0;
               for (int i = 0; i < MAX_DIGITS; i++) begin
                  digit_store_in[i] = 4'd0;
               end
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            digit_store_in[0] = {adj[0][2:0], mag_ff[31]};
            for (int i = 1; i < MAX_DIGITS; i++) begin
               digit_store_in[i] = {adj[i][2:0], adj[i-1][3]};
            end
            mag_in          = {mag_ff[30:0], 1'b0};
            emit_counter_in = emit_counter_ff + 7'd1;
            if (emit_counter_ff == 7'(MAG_BITS - 1)) begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            digit_count_in = count_v;
            state_in       = ST_ZERO;
         end
         ST_ZERO: begin
            zero_in  = zero_v;
            used_in  = len + {3'd0, req_ff.plus_sign && pos} + {3'd0, req_ff.space_sign && pos};
            state_in = ST_LAYOUT;
         end
         ST_LAYOUT: begin
            emit_counter_in = 7'd0;
            dptr_in         = digit_count_ff - 4'd1;
            state_in        = (total_in == 7'd0) ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            if (load) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.ascii_char = char_v;
               rsp_data_in.last_char  = (emit_counter_ff == total_ff - 7'd1);
               emit_counter_in        = emit_counter_ff + 7'd1;
               if (is_digit) begin
                  dptr_in = dptr_ff - 4'd1;
               end
               if (emit_counter_ff == total_ff - 7'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         digit_count_ff  <= 4'd0;
         emit_counter_ff <= 7'd0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         digit_count_ff  <= digit_count_in;
         emit_counter_ff <= emit_counter_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      mag_ff         <= mag_in;
      digit_store_ff <= digit_store_in;
      zero_ff        <= zero_in;
      used_ff        <= used_in;
      dptr_ff        <= dptr_in;
      rsp_data_ff    <= rsp_data_in;
      if (state_ff == ST_LAYOUT) begin
         b_sp_ff   <= b_sp_in;
         b_lpad_ff <= b_lpad_in;
         b_sign_ff <= b_sign_in;
         b_zero_ff <= b_zero_in;
         b_dig_ff  <= b_dig_in;
         total_ff  <= total_in;
      end
   end

   // An accepted request keeps the sequencer busy for at least the conversion.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a conversion is in progress");

   // While digits are being built, only the last character of the previous field may wait.
   a_pending_is_last: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_CONV) && rsp_valid_ff) |-> rsp_data_ff.last_char)
      else $error("field characters still pending during conversion");

   // A field never runs past its layout or past 64 characters.
   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> ((emit_counter_ff < total_ff) && (total_ff <= 7'd64)))
      else $error("character position beyond field length");

   // A last character that is still waiting when the next field starts emitting holds
   // that field at its first position.
   a_last_ends_field: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ready && rsp_data_ff.last_char) |->
         ((state_ff != ST_EMIT) || (emit_counter_ff == 7'd0)))
      else $error("last character sent while the field is still emitting");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import sdff_pkg::*;

   localparam int RANDOM_ITEMS = 290;
   localparam int HOLD_AT      = 200;
   localparam int HOLD_CYCLES  = 600;
   localparam int DRAIN_CYCLES = 120;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type req_pending[$];
   rsp_type expected_chars[$];
   int      total_items;
   int      accepted_count = 0;
   int      mismatch_count = 0;

   signed_decimal_field_formatter_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // Flags are packed in struct order: left_justify, zero_pad, has_precision,
   // space_sign, plus_sign.
   function automatic req_type make_spec(input logic [31:0] v, input logic [4:0] flags,
                                         input int w, input int p);
      req_type r;
      r = '0;
      r.value = v;
      {r.left_justify, r.zero_pad, r.has_precision, r.space_sign, r.plus_sign} = flags;
      r.field_width = w[5:0];
      r.min_digits  = p[5:0];
      return r;
   endfunction

   // Lays out the formatted field and queues one expected character per position.
   function automatic void format_field(input req_type r);
      logic [31:0] u;
      logic [31:0] mag;
      bit          neg, pos, lj, zp, hp, sp, pl;
      int          w, p, len, zero, j, pad, dcount, k;
      int          digits[MAX_DIGITS];
      logic [7:0]  chars[$];
      logic [7:0]  fill;
      rsp_type     item;
      u   = r.value;
      neg = u[31];
      pos = !neg;
      mag = neg ? (32'd0 - u) : u;
      lj  = r.left_justify;
      zp  = r.zero_pad;
      hp  = r.has_precision;
      sp  = r.space_sign;
      pl  = r.plus_sign;
      w   = r.field_width;
      p   = r.min_digits;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (p > PREC_CAP) p = PREC_CAP;

      dcount = 0;
      do begin
         digits[dcount] = int'(mag % 32'd10);
         dcount++;
         mag = mag / 32'd10;
      end while (mag != 0 && dcount < MAX_DIGITS);

      if (u == 0 && hp && p == 0) len = 0;
      else len = dcount + (neg ? 1 : 0);

      // The zero-fill count may go negative once the sign characters take
      // their share; it still feeds the padding arithmetic.
      zero = 0;
      if (zp || hp) begin
         if (hp && pos && p > len) zero = p - len;
         else if (hp && neg && p > len - 1) zero = p - len + 1;
         else if (zp && !hp && w > len) zero = w - len;
         if (sp && !hp && pos) zero--;
         if (pl && !hp && pos) zero--;
      end

      j = len;
      if (pl && pos) j++;
      if (sp && pos) begin
         j++;
         chars.push_back(CHAR_SPACE);
      end
      if (!lj) begin
         fill = (zp && !hp) ? CHAR_ZERO : CHAR_SPACE;
         for (pad = w - zero - j; pad > 0; pad--) begin
            j++;
            chars.push_back(fill);
         end
      end
      if (pl && pos) chars.push_back(CHAR_PLUS);
      if (pos) for (k = 0; k < zero; k++) chars.push_back(CHAR_ZERO);
      if (!hp || p != 0 || u != 0) begin
         if (neg) begin
            chars.push_back(CHAR_MINUS);
            for (k = 0; k < zero; k++) chars.push_back(CHAR_ZERO);
         end
         for (k = dcount - 1; k >= 0; k--) chars.push_back(CHAR_ZERO + 8'(digits[k]));
      end
      if (lj) for (pad = w - zero - j; pad > 0; pad--) chars.push_back(CHAR_SPACE);

      while (chars.size() > 64) void'(chars.pop_back());
      foreach (chars[i]) begin
         item.ascii_char = chars[i];
         item.last_char  = (i == chars.size() - 1);
         expected_chars.push_back(item);
      end
   endfunction

   // Request driver: one transfer per accepted spec, with a random gap after each.
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            format_field(req_data);
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (req_pending.size() > 0) begin
               req_data  <= req_pending.pop_front();
               req_valid <= 1'b1;
               gap_left = ((accepted_count / 40) % 3 == 2) ? 0 : $urandom_range(0, 12);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Character monitor: checks each transfer and stalls at random, with one long
   // hold-off so that the block backs up into its request side.
   int stall_left = 0;
   int hold_left  = 0;
   int rsp_seen   = 0;
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected character, expected none, actual %h last %b",
                        $time, rsp_data.ascii_char, rsp_data.last_char);
               mismatch_count++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_data.ascii_char !== want.ascii_char) begin
                  $display("%0t: ascii_char mismatch, expected %h, actual %h",
                           $time, want.ascii_char, rsp_data.ascii_char);
                  mismatch_count++;
               end
               if (rsp_data.last_char !== want.last_char) begin
                  $display("%0t: last_char mismatch, expected %b, actual %b",
                           $time, want.last_char, rsp_data.last_char);
                  mismatch_count++;
               end
            end
            rsp_seen++;
            if (rsp_seen == HOLD_AT) hold_left = HOLD_CYCLES;
            stall_left = ((rsp_seen / 100) % 3 == 1) ? 0 : $urandom_range(0, 12);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      req_type     r;
      logic [31:0] v;
      // Directed cases.
      req_pending.push_back(make_spec(32'd0,          5'b00000,  0,  0));
      req_pending.push_back(make_spec(32'd0,          5'b00100,  0,  0));  // empty field
      req_pending.push_back(make_spec(32'd0,          5'b00100,  5,  0));
      req_pending.push_back(make_spec(32'h8000_0000,  5'b00000,  0,  0));
      req_pending.push_back(make_spec(32'h8000_0000,  5'b01000, 15,  0));
      req_pending.push_back(make_spec(32'h7FFF_FFFF,  5'b00001,  0,  0));
      req_pending.push_back(make_spec(32'd123,        5'b00011, 10,  0));
      req_pending.push_back(make_spec(32'd123,        5'b01011, 10,  0));
      req_pending.push_back(make_spec(32'd12345,      5'b01011,  3,  0));
      req_pending.push_back(make_spec(-32'sd77,       5'b01000,  8,  0));
      req_pending.push_back(make_spec(-32'sd77,       5'b00100, 10,  6));
      req_pending.push_back(make_spec(32'd5,          5'b00100, 63, 61));
      req_pending.push_back(make_spec(32'hFFFF_FFFF,  5'b00100, 63, 63));
      req_pending.push_back(make_spec(-32'sd456,      5'b10000, 12,  0));
      req_pending.push_back(make_spec(32'd789,        5'b11000,  9,  0));
      req_pending.push_back(make_spec(32'd0,          5'b10011, 20,  0));
      req_pending.push_back(make_spec(-32'sd9,        5'b00011,  5,  0));
      req_pending.push_back(make_spec(32'd33,         5'b01100,  8,  4));
      req_pending.push_back(make_spec(32'd0,          5'b10000, 63,  0));
      req_pending.push_back(make_spec(32'hFFFF_FFFF,  5'b11111, 63, 63));
      req_pending.push_back(make_spec(32'h7FFF_FFFF,  5'b01011, 63,  0));
      req_pending.push_back(make_spec(32'd1000000000, 5'b00000,  0,  0));
      req_pending.push_back(make_spec(32'h8000_0000,  5'b00100, 20, 15));
      req_pending.push_back(make_spec(32'd0,          5'b00111,  0,  0));

      repeat (RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 400) - 200;
            1: case ($urandom_range(0, 3))
                  0: v = 32'h8000_0000;
                  1: v = 32'h7FFF_FFFF;
                  2: v = 32'd0;
                  default: v = 32'hFFFF_FFFF;
               endcase
            2: v = $urandom_range(0, 99999);
            default: v = $urandom;
         endcase
         r = make_spec(v, 5'($urandom_range(0, 31)),
                       ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 16),
                       ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 12));
         req_pending.push_back(r);
      end
      total_items = req_pending.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_items) @(posedge clock);
      while (expected_chars.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

### signed_decimal_field_formatter_core.f
rtl/core/sdff_pkg.sv
rtl/core/signed_decimal_field_formatter_core.sv
tb/tb_top.sv
